// ===== design/i2c_master_transfer_sequencer_unit_macros.svh =====
// ----------------------------------------------------------------------------
// I2C master transfer sequencer assertion macros
// Implication checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_TRANSFER_SEQUENCER_UNIT_MACROS_SVH
`define I2C_MASTER_TRANSFER_SEQUENCER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define I2CMS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same cycle implication");
`define I2CMS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next cycle implication");
`else
`define I2CMS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define I2CMS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== design/i2cms_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C master transfer sequencer package
// Word types, command and action codes, and sizing constants.
// ----------------------------------------------------------------------------
package i2cms_pkg;

  localparam int BUFFER_DEPTH_DEF = 16;
  localparam int COUNT_W          = 6;

  localparam logic [4:0] MAX_LEN = 5'd16;

  localparam logic [1:0] CMD_LOAD      = 2'd0;
  localparam logic [1:0] CMD_START     = 2'd1;
  localparam logic [1:0] CMD_BYTE_DONE = 2'd2;

  localparam logic [2:0] ACT_NONE  = 3'd0;
  localparam logic [2:0] ACT_START = 3'd1;
  localparam logic [2:0] ACT_SEND  = 3'd2;
  localparam logic [2:0] ACT_ACK   = 3'd3;
  localparam logic [2:0] ACT_NACK  = 3'd4;
  localparam logic [2:0] ACT_STOP  = 3'd5;

  typedef struct packed {
    logic [1:0] command;
    logic [3:0] load_index;
    logic [7:0] load_data;
    logic [6:0] device_address;
    logic       read_mode;
    logic [4:0] byte_count;
    logic       bus_nack;
    logic [7:0] bus_rx_byte;
  } in_word_t;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] bus_tx_byte;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic [3:0] rx_position;
    logic       no_device;
    logic       message_done;
  } out_word_t;

  typedef struct packed {
    logic       en;
    logic [3:0] addr;
    logic [7:0] data;
  } buf_wr_t;

endpackage

// ===== design/i2cms_txbuf.sv =====
// ----------------------------------------------------------------------------
// I2C master transfer sequencer transmit buffer
// Byte memory with one write port and one registered prefetch read port.
// ----------------------------------------------------------------------------
module i2cms_txbuf #(
  parameter int BUFFER_DEPTH = i2cms_pkg::BUFFER_DEPTH_DEF
) (
  input  logic                          clk,
  input  i2cms_pkg::buf_wr_t            wr,
  input  logic [i2cms_pkg::COUNT_W-1:0] pf_slot,
  output logic [7:0]                    pf_data
);
  import i2cms_pkg::*;

  localparam int IDX_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

  logic [7:0]             mem [BUFFER_DEPTH];
  logic [IDX_W+3:0]       wr_wide;
  logic [IDX_W+COUNT_W-1:0] pf_wide;
  logic [IDX_W-1:0]       wr_idx;
  logic [IDX_W-1:0]       pf_idx;
  logic                   wr_ok;
  logic                   pf_ok;
  logic [7:0]             rd_data_r;
  logic                   rd_ok_r;

  assign wr_wide = (IDX_W + 4)'(wr.addr);
  assign pf_wide = (IDX_W + COUNT_W)'(pf_slot);
  assign wr_idx  = wr_wide[IDX_W-1:0];
  assign pf_idx  = pf_wide[IDX_W-1:0];
  assign wr_ok   = wr.en && (wr_wide < (IDX_W + 4)'(BUFFER_DEPTH));
  assign pf_ok   = pf_wide < (IDX_W + COUNT_W)'(BUFFER_DEPTH);

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wr_idx] <= wr.data;
    end
  end

  // bypass a write to the slot being fetched
  always_ff @(posedge clk) begin
    rd_ok_r <= pf_ok;
    if (wr_ok && (wr_idx == pf_idx)) begin
      rd_data_r <= wr.data;
    end else begin
      rd_data_r <= mem[pf_idx];
    end
  end

  assign pf_data = rd_ok_r ? rd_data_r : 8'd0;

endmodule

// ===== design/i2cms_core.sv =====
// ----------------------------------------------------------------------------
// I2C master transfer sequencer core
// Message state registers and next-state logic for one word per cycle on advance.
// ----------------------------------------------------------------------------
module i2cms_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          advance,
  input  i2cms_pkg::in_word_t           word,
  input  logic [7:0]                    pf_data,
  output i2cms_pkg::buf_wr_t            wr,
  output logic [i2cms_pkg::COUNT_W-1:0] pf_slot,
  output i2cms_pkg::out_word_t          result
);
  import i2cms_pkg::*;

  logic [COUNT_W-1:0] transfer_count_r, transfer_count_nxt;
  logic               is_read_r, is_read_nxt;
  logic [4:0]         message_length_r, message_length_nxt;
  logic               busy_r, busy_nxt;
  logic [COUNT_W-1:0] cnt;
  logic [COUNT_W-1:0] len_ext;

  assign cnt     = transfer_count_r + COUNT_W'(1);
  assign len_ext = COUNT_W'(message_length_r);

  always_comb begin
    transfer_count_nxt = transfer_count_r;
    is_read_nxt        = is_read_r;
    message_length_nxt = message_length_r;
    busy_nxt           = busy_r;
    result             = '0;
    wr.en              = 1'b0;
    wr.addr            = word.load_index;
    wr.data            = word.load_data;
    if (advance) begin
      unique case (word.command)
        CMD_LOAD: begin
          wr.en = 1'b1;
        end
        CMD_START: begin
          if (!busy_r) begin
            busy_nxt           = 1'b1;
            is_read_nxt        = word.read_mode;
            message_length_nxt = (word.byte_count > MAX_LEN) ? MAX_LEN : word.byte_count;
            transfer_count_nxt = '1;
            result.action      = ACT_START;
            result.bus_tx_byte = {word.device_address, word.read_mode};
          end
        end
        CMD_BYTE_DONE: begin
          if (busy_r) begin
            transfer_count_nxt = cnt;
            if (cnt == '0) begin
              if (word.bus_nack) begin
                result.action       = ACT_STOP;
                result.no_device    = 1'b1;
                result.message_done = 1'b1;
                busy_nxt            = 1'b0;
              end else if (message_length_r == 5'd0) begin
                result.action       = ACT_STOP;
                result.message_done = 1'b1;
                busy_nxt            = 1'b0;
              end else if (!is_read_r) begin
                result.action      = ACT_SEND;
                result.bus_tx_byte = pf_data;
              end else begin
                result.action = (message_length_r == 5'd1) ? ACT_NACK : ACT_ACK;
              end
            end else if (!is_read_r) begin
              if (cnt < len_ext) begin
                result.action      = ACT_SEND;
                result.bus_tx_byte = pf_data;
              end else begin
                result.action       = ACT_STOP;
                result.message_done = 1'b1;
                busy_nxt            = 1'b0;
              end
            end else begin
              result.rx_valid    = 1'b1;
              result.rx_byte     = word.bus_rx_byte;
              result.rx_position = cnt[3:0] - 4'd1;
              if (cnt < len_ext) begin
                result.action = (cnt == len_ext - COUNT_W'(1)) ? ACT_NACK : ACT_ACK;
              end else begin
                result.action       = ACT_STOP;
                result.message_done = 1'b1;
                busy_nxt            = 1'b0;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // fetch the slot the next byte done will send
  assign pf_slot = transfer_count_nxt + COUNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      transfer_count_r <= '1;
      is_read_r        <= 1'b0;
      message_length_r <= 5'd0;
      busy_r           <= 1'b0;
    end else begin
      transfer_count_r <= transfer_count_nxt;
      is_read_r        <= is_read_nxt;
      message_length_r <= message_length_nxt;
      busy_r           <= busy_nxt;
    end
  end

endmodule

// ===== design/i2c_master_transfer_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// I2C master transfer sequencer unit
// Words pass the input register, then the result register, to the output.
// One word per cycle unless stalled; each word gives exactly one result word.
// The transmit buffer is read ahead through a registered port.
// Reset clears message state to idle; buffer contents stay undefined.
// ----------------------------------------------------------------------------
`include "i2c_master_transfer_sequencer_unit_macros.svh"

module i2c_master_transfer_sequencer_unit #(
  parameter int BUFFER_DEPTH = i2cms_pkg::BUFFER_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  i2cms_pkg::in_word_t  in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output i2cms_pkg::out_word_t out_word
);
  import i2cms_pkg::*;

  logic               in_valid_r, in_valid_nxt;
  in_word_t           in_word_r;
  logic               out_valid_r, out_valid_nxt;
  out_word_t          out_word_r;
  logic               advance;
  logic               accept;
  buf_wr_t            wr;
  logic [COUNT_W-1:0] pf_slot;
  logic [7:0]         pf_data;
  out_word_t          result;
  logic               out_done;
  logic               out_nodev;

  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;
  assign accept   = in_valid && !in_stall;

  i2cms_txbuf #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_txbuf (
    .clk     (clk),
    .wr      (wr),
    .pf_slot (pf_slot),
    .pf_data (pf_data)
  );

  i2cms_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .word    (in_word_r),
    .pf_data (pf_data),
    .wr      (wr),
    .pf_slot (pf_slot),
    .result  (result)
  );

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (accept) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r && out_stall;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_word_r <= in_word;
    end
    if (advance) begin
      out_word_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign out_done  = out_valid && out_word.message_done;
  assign out_nodev = out_valid && out_word.no_device;

  `I2CMS_ASSERT_NXT(a_advance_loads_result, clk, rst_n, advance, out_valid)
  `I2CMS_ASSERT_IMP(a_stall_when_full, clk, rst_n, in_stall, in_valid_r && out_valid && out_stall)
  `I2CMS_ASSERT_IMP(a_done_is_stop, clk, rst_n, out_done, out_word.action == ACT_STOP)
  `I2CMS_ASSERT_IMP(a_nodev_ends_message, clk, rst_n, out_nodev, out_done && !out_word.rx_valid)

endmodule
